FILE: hw/rtl/dcs_pkg.sv
// Shared types and constants for the dryer cycle sequencer.
package dcs_pkg;

  localparam int COUNT_WIDTH_DEF = 10;
  localparam int CFG_W           = 10;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_W-1:0] HEATER_TICKS_RST = 10'd600;
  localparam logic [CFG_W-1:0] FAN_MIN_RST      = 10'd500;
  localparam logic [CFG_W-1:0] PUMP_TICKS_RST   = 10'd500;

  localparam logic [6:0] TEMP_TOP  = 7'd99;
  localparam logic [6:0] TEMP_LOW  = 7'd25;
  localparam logic [7:0] HUM_START = 8'd72;

  localparam logic [7:0] DRIVE_OFF  = 8'h00;
  localparam logic [7:0] DRIVE_HEAT = 8'hA0;
  localparam logic [7:0] DRIVE_FAN  = 8'h40;
  localparam logic [7:0] DRIVE_PUMP = 8'h18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEATER_TICKS = 2'd0,
    REG_FAN_MIN      = 2'd1,
    REG_PUMP_TICKS   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SET_TEMP = 3'd1,
    PH_SET_HUM  = 3'd2,
    PH_HEAT     = 3'd3,
    PH_CHECK    = 3'd4,
    PH_FAN      = 3'd5,
    PH_PUMP     = 3'd6
  } phase_t;

  typedef struct packed {
    logic       next_button_level;
    logic       adjust_button_level;
    logic [7:0] humidity_reading;
    logic [7:0] temperature_reading;
  } in_item_t;

  typedef struct packed {
    logic [7:0] drive_pattern;
    logic [2:0] phase;
    logic [6:0] temp_setpoint_out;
    logic [7:0] hum_setpoint_out;
  } out_item_t;

endpackage

FILE: hw/rtl/dryer_cycle_sequencer_core.sv
// Dryer cycle sequencer: phase control, press detection, setpoints and run timers.
// An accepted item's result is loaded into the output register at the edge that takes it;
//   out_valid is then high until that result is taken.
// Throughput: one item per cycle; in_ready stays high while the output register is empty
//   or is being taken in the same cycle.
// Reset (rst, synchronous): idle phase, detectors clear, setpoints 25 and 72, counters 0,
//   drive off, config registers 600/500/500, output register empty.
module dryer_cycle_sequencer_core #(
  parameter int COUNT_WIDTH = dcs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dcs_pkg::in_item_t           in_item,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output dcs_pkg::out_item_t          out_item,
  // configuration write port
  input  logic                        cfg_write,
  input  logic [dcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcs_pkg::CFG_W-1:0]   cfg_data
);

  // Counter and register compared at the wider of the two widths, so a
  // register above the counter's range never ends the phase.
  localparam int CMP_W = (COUNT_WIDTH > dcs_pkg::CFG_W) ? COUNT_WIDTH : dcs_pkg::CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_TOP = {COUNT_WIDTH{1'b1}};

  // configuration registers
  logic [dcs_pkg::CFG_W-1:0] heater_ticks, fan_min_ticks, pump_ticks;

  // sequencer state
  dcs_pkg::phase_t           phase_reg, phase_next;
  logic                      next_press_seen, next_press_seen_next;
  logic                      adjust_press_seen, adjust_press_seen_next;
  logic [6:0]                temp_setpoint, temp_setpoint_next;
  logic [7:0]                hum_setpoint, hum_setpoint_next;
  logic [COUNT_WIDTH-1:0]    heater_count, heater_count_next;
  logic [COUNT_WIDTH-1:0]    fan_count, fan_count_next;
  logic [COUNT_WIDTH-1:0]    pump_count, pump_count_next;
  logic [7:0]                drive_reg, drive_next;

  // output register
  dcs_pkg::out_item_t        out_reg;
  logic                      out_full;

  // press events: a pressed level (0) while the detector is clear
  logic next_event, adjust_event;
  logic [6:0] temp_inc;
  logic [7:0] hum_dec;
  logic [COUNT_WIDTH-1:0] heater_inc, pump_inc, fan_sat;
  logic in_take;

  assign in_ready  = !out_full || out_ready;
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_full;
  assign out_item  = out_reg;

  assign next_event   = !in_item.next_button_level && !next_press_seen;
  assign adjust_event = !in_item.adjust_button_level && !adjust_press_seen;

  assign temp_inc   = temp_setpoint + 7'd1;
  assign hum_dec    = hum_setpoint - 8'd1;
  assign heater_inc = heater_count + CNT_ONE;
  assign pump_inc   = pump_count + CNT_ONE;
  assign fan_sat    = (fan_count < CNT_TOP) ? fan_count + CNT_ONE : fan_count;

  // configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      heater_ticks  <= dcs_pkg::HEATER_TICKS_RST;
      fan_min_ticks <= dcs_pkg::FAN_MIN_RST;
      pump_ticks    <= dcs_pkg::PUMP_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dcs_pkg::REG_HEATER_TICKS: heater_ticks  <= cfg_data;
        dcs_pkg::REG_FAN_MIN:      fan_min_ticks <= cfg_data;
        dcs_pkg::REG_PUMP_TICKS:   pump_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // next-state logic for one tick
  always_comb begin
    phase_next             = phase_reg;
    next_press_seen_next   = next_press_seen;
    adjust_press_seen_next = adjust_press_seen;
    temp_setpoint_next     = temp_setpoint;
    hum_setpoint_next      = hum_setpoint;
    heater_count_next      = heater_count;
    fan_count_next         = fan_count;
    pump_count_next        = pump_count;
    drive_next             = drive_reg;

    unique case (phase_reg)
      dcs_pkg::PH_SET_TEMP: begin
        adjust_press_seen_next = !in_item.adjust_button_level;
        next_press_seen_next   = !in_item.next_button_level;
        if (adjust_event) begin
          temp_setpoint_next = (temp_inc >= dcs_pkg::TEMP_TOP) ? dcs_pkg::TEMP_LOW : temp_inc;
        end
        if (next_event) begin
          phase_next = dcs_pkg::PH_SET_HUM;
        end
      end
      dcs_pkg::PH_SET_HUM: begin
        adjust_press_seen_next = !in_item.adjust_button_level;
        next_press_seen_next   = !in_item.next_button_level;
        if (adjust_event) begin
          hum_setpoint_next = (hum_dec == 8'd0) ? dcs_pkg::HUM_START : hum_dec;
        end
        if (next_event) begin
          phase_next = dcs_pkg::PH_HEAT;
        end
      end
      dcs_pkg::PH_HEAT: begin
        drive_next = dcs_pkg::DRIVE_HEAT;
        if (CMP_W'(heater_inc) >= CMP_W'(heater_ticks)) begin
          heater_count_next = '0;
          phase_next        = dcs_pkg::PH_CHECK;
        end else begin
          heater_count_next = heater_inc;
        end
      end
      dcs_pkg::PH_CHECK: begin
        phase_next = (in_item.humidity_reading > hum_setpoint) ? dcs_pkg::PH_FAN
                                                               : dcs_pkg::PH_PUMP;
      end
      dcs_pkg::PH_FAN: begin
        drive_next = dcs_pkg::DRIVE_FAN;
        if ((CMP_W'(fan_sat) >= CMP_W'(fan_min_ticks)) &&
            (in_item.humidity_reading <= hum_setpoint)) begin
          fan_count_next = '0;
          phase_next     = dcs_pkg::PH_PUMP;
        end else begin
          fan_count_next = fan_sat;
        end
      end
      dcs_pkg::PH_PUMP: begin
        drive_next = dcs_pkg::DRIVE_PUMP;
        if (CMP_W'(pump_inc) >= CMP_W'(pump_ticks)) begin
          pump_count_next = '0;
          phase_next = (in_item.temperature_reading >= {1'b0, temp_setpoint}) ?
                       dcs_pkg::PH_IDLE : dcs_pkg::PH_HEAT;
        end else begin
          pump_count_next = pump_inc;
        end
      end
      default: begin
        // idle, and the unused code, which acts as idle
        drive_next           = dcs_pkg::DRIVE_OFF;
        next_press_seen_next = !in_item.next_button_level;
        phase_next = next_event ? dcs_pkg::PH_SET_TEMP : dcs_pkg::PH_IDLE;
      end
    endcase
  end

  // state advances once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= dcs_pkg::PH_IDLE;
      next_press_seen   <= 1'b0;
      adjust_press_seen <= 1'b0;
      temp_setpoint     <= dcs_pkg::TEMP_LOW;
      hum_setpoint      <= dcs_pkg::HUM_START;
      heater_count      <= '0;
      fan_count         <= '0;
      pump_count        <= '0;
      drive_reg         <= dcs_pkg::DRIVE_OFF;
    end else if (in_take) begin
      phase_reg         <= phase_next;
      next_press_seen   <= next_press_seen_next;
      adjust_press_seen <= adjust_press_seen_next;
      temp_setpoint     <= temp_setpoint_next;
      hum_setpoint      <= hum_setpoint_next;
      heater_count      <= heater_count_next;
      fan_count         <= fan_count_next;
      pump_count        <= pump_count_next;
      drive_reg         <= drive_next;
    end
  end

  // result register; loads with the post-tick values
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (in_take) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_reg.drive_pattern     <= drive_next;
      out_reg.phase             <= phase_next;
      out_reg.temp_setpoint_out <= temp_setpoint_next;
      out_reg.hum_setpoint_out  <= hum_setpoint_next;
    end
  end

endmodule

FILE: bench/tb_dryer_cycle_sequencer_core.sv
// Self-checking testbench for the dryer cycle sequencer core: tick predictor, scoreboard, tests.
module tb_dryer_cycle_sequencer_core;
  import dcs_pkg::*;

  localparam int COUNT_W = COUNT_WIDTH_DEF;
  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 2'd3;
  localparam int MAX_GAP = 18;
  localparam int HOLD_CYCLES = 300;     // long output hold-off for the back-pressure test
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no handshake or register write

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  dryer_cycle_sequencer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer state as the bench sees it; starts at the post-reset values.
  // ---------------------------------------------------------------------------
  phase_t cur_phase = PH_IDLE;
  logic next_latched = 1'b0;
  logic adjust_latched = 1'b0;
  logic [6:0] temp_set = TEMP_LOW;
  logic [7:0] hum_set = HUM_START;
  logic [COUNT_W-1:0] heat_count = '0;
  logic [COUNT_W-1:0] fan_count = '0;
  logic [COUNT_W-1:0] pump_count = '0;
  logic [7:0] drive_now = DRIVE_OFF;
  logic [CFG_W-1:0] heat_limit = HEATER_TICKS_RST;
  logic [CFG_W-1:0] fan_limit = FAN_MIN_RST;
  logic [CFG_W-1:0] pump_limit = PUMP_TICKS_RST;

  out_item_t pending_results[$];

  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned full_cycles = 0;
  int unsigned temp_wraps = 0;
  int unsigned hum_wraps = 0;
  int unsigned holds_done = 0;

  // Idling switches for each side, and a one-shot request for a long output hold-off.
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_request = 1'b0;

  // Advance the sequencer by one tick and return the item it should emit.
  // A press event is a pressed level (0) while the detector is clear; after
  // polling, the detector simply mirrors "pressed". Detectors move only in
  // the phases that poll them; adjust is polled before advance.
  function automatic out_item_t step_dryer(input in_item_t it);
    logic adjust_event;
    logic next_event;
    logic [6:0] temp_inc;
    logic [7:0] hum_dec;
    out_item_t r;
    adjust_event = !it.adjust_button_level && !adjust_latched;
    next_event = !it.next_button_level && !next_latched;
    case (cur_phase)
      PH_SET_TEMP: begin
        adjust_latched = !it.adjust_button_level;
        next_latched = !it.next_button_level;
        if (adjust_event) begin
          temp_inc = temp_set + 7'd1;
          if (temp_inc >= TEMP_TOP) begin
            temp_set = TEMP_LOW;
            temp_wraps++;
          end else begin
            temp_set = temp_inc;
          end
        end
        if (next_event) cur_phase = PH_SET_HUM;
      end
      PH_SET_HUM: begin
        adjust_latched = !it.adjust_button_level;
        next_latched = !it.next_button_level;
        if (adjust_event) begin
          hum_dec = hum_set - 8'd1;
          if (hum_dec == 8'd0) begin
            hum_set = HUM_START;
            hum_wraps++;
          end else begin
            hum_set = hum_dec;
          end
        end
        if (next_event) cur_phase = PH_HEAT;
      end
      PH_HEAT: begin
        drive_now = DRIVE_HEAT;
        heat_count = heat_count + 1'b1;
        if (heat_count >= heat_limit) begin
          heat_count = '0;
          cur_phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        cur_phase = (it.humidity_reading > hum_set) ? PH_FAN : PH_PUMP;
      end
      PH_FAN: begin
        drive_now = DRIVE_FAN;
        if (fan_count != {COUNT_W{1'b1}}) fan_count = fan_count + 1'b1;
        if (fan_count >= fan_limit && it.humidity_reading <= hum_set) begin
          fan_count = '0;
          cur_phase = PH_PUMP;
        end
      end
      PH_PUMP: begin
        drive_now = DRIVE_PUMP;
        pump_count = pump_count + 1'b1;
        if (pump_count >= pump_limit) begin
          pump_count = '0;
          if (it.temperature_reading >= {1'b0, temp_set}) begin
            cur_phase = PH_IDLE;
            full_cycles++;
          end else begin
            cur_phase = PH_HEAT;
          end
        end
      end
      default: begin
        // idle, and the unused code that behaves as idle; only advance is polled
        drive_now = DRIVE_OFF;
        cur_phase = PH_IDLE;
        next_latched = !it.next_button_level;
        if (next_event) cur_phase = PH_SET_TEMP;
      end
    endcase
    r.drive_pattern = drive_now;
    r.phase = cur_phase;
    r.temp_setpoint_out = temp_set;
    r.hum_setpoint_out = hum_set;
    return r;
  endfunction

  function automatic in_item_t tick(input logic nxt, input logic adj,
                                    input logic [7:0] hum, input logic [7:0] temp);
    in_item_t it;
    it.next_button_level = nxt;
    it.adjust_button_level = adj;
    it.humidity_reading = hum;
    it.temperature_reading = temp;
    return it;
  endfunction

  // Random buttons; readings often sit right at the setpoints so that the
  // check, fan exit and pump decision go both ways.
  function automatic in_item_t random_tick();
    in_item_t it;
    it.next_button_level = 1'($urandom_range(0, 1));
    it.adjust_button_level = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: it.humidity_reading = 8'($urandom_range(0, 255));
      1: it.humidity_reading = hum_set;
      2: it.humidity_reading = hum_set + 8'd1;
      default: it.humidity_reading = hum_set - 8'd1;
    endcase
    case ($urandom_range(0, 3))
      0: it.temperature_reading = 8'($urandom_range(0, 255));
      1: it.temperature_reading = {1'b0, temp_set};
      2: it.temperature_reading = {1'b0, temp_set} + 8'd1;
      default: it.temperature_reading = {1'b0, temp_set} - 8'd1;
    endcase
    return it;
  endfunction

  // Offer one item and wait for it to be taken. Valid stays high when the
  // next item follows without a gap; the result is predicted at acceptance.
  task automatic send_tick(input in_item_t it);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(step_dryer(it));
    items_sent++;
  endtask

  // Every item yields exactly one result, so an empty queue means the core is quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_write high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_HEATER_TICKS: heat_limit = val;
      REG_FAN_MIN: fan_limit = val;
      REG_PUMP_TICKS: pump_limit = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] heat, input logic [CFG_W-1:0] fan,
                           input logic [CFG_W-1:0] pump);
    wait_drained();
    write_reg(REG_HEATER_TICKS, heat);
    write_reg(REG_FAN_MIN, fan);
    write_reg(REG_PUMP_TICKS, pump);
    write_reg(UNUSED_REG, CFG_W'($urandom_range(0, 1023)));
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: per-result stall draw, plus the long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned wait_cycles;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      wait_cycles = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard: each taken result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("drive_pattern", want.drive_pattern, out_item.drive_pattern);
        check_field("phase", want.phase, out_item.phase);
        check_field("temp_setpoint_out", want.temp_setpoint_out, out_item.temp_setpoint_out);
        check_field("hum_setpoint_out", want.hum_setpoint_out, out_item.hum_setpoint_out);
        results_checked++;
      end
    end
  end

  // Watchdog: any handshake or register write restarts the count.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: watchdog: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, press detection, polling order and two short drying cycles.
  task automatic test_presses_and_phases();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_tick(tick(1'b1, 1'b1, 8'h00, 8'h00));
    // adjust is not polled in idle, so its detector stays clear
    send_tick(tick(1'b1, 1'b0, 8'hFF, 8'hFF));
    configure(10'd3, 10'd2, 10'd2);
    send_tick(tick(1'b0, 1'b0, 8'hAA, 8'h55));   // advance -> set temp
    send_tick(tick(1'b0, 1'b0, 8'h55, 8'hAA));   // held adjust first seen here
    send_tick(tick(1'b1, 1'b1, 8'h0F, 8'hF0));
    send_tick(tick(1'b0, 1'b0, 8'hF0, 8'h0F));   // both: bump temp, then leave
    send_tick(tick(1'b1, 1'b1, 8'h01, 8'h80));
    send_tick(tick(1'b1, 1'b0, 8'h80, 8'h01));   // humidity down
    send_tick(tick(1'b1, 1'b1, 8'h7E, 8'h81));
    send_tick(tick(1'b1, 1'b0, 8'h81, 8'h7E));
    send_tick(tick(1'b0, 1'b0, 8'h3C, 8'hC3));   // adjust still held: only advance
    repeat (3) send_tick(tick(1'b1, 1'b1, 8'h33, 8'hCC));
    send_tick(tick(1'b0, 1'b0, hum_set + 8'd1, 8'h00));  // check: too humid -> fan
    send_tick(tick(1'b1, 1'b1, 8'd200, 8'h00));
    send_tick(tick(1'b1, 1'b1, 8'd200, 8'h00));  // count reached, still humid
    send_tick(tick(1'b1, 1'b1, hum_set, 8'h00)); // dry enough -> pump
    send_tick(tick(1'b1, 1'b1, 8'h00, {1'b0, temp_set} - 8'd1));
    send_tick(tick(1'b1, 1'b1, 8'h00, {1'b0, temp_set}));  // warm enough -> idle
    // second pass: humidity at setpoint skips the fan, cool pump goes back to heat
    repeat (3) begin
      send_tick(tick(1'b1, 1'b1, 8'h5A, 8'hA5));
      send_tick(tick(1'b0, 1'b1, 8'hA5, 8'h5A));
    end
    repeat (3) send_tick(tick(1'b1, 1'b1, 8'h66, 8'h99));
    send_tick(tick(1'b1, 1'b1, hum_set, 8'h00));
    repeat (2) send_tick(tick(1'b1, 1'b1, 8'h00, {1'b0, temp_set} - 8'd1));
  endtask

  // Zero limits end each run phase after one tick; fan leaves as soon as it is dry.
  task automatic test_zero_limits();
    configure('0, '0, '0);
    repeat (16) send_tick(random_tick());
  endtask

  // Walk both setpoints through their wrap points, one press past each.
  task automatic test_setpoint_wrap();
    int unsigned presses;
    while (cur_phase != PH_SET_TEMP) send_tick(random_tick());
    presses = int'(TEMP_TOP - temp_set) + 1;
    repeat (presses) begin
      send_tick(tick(1'b1, 1'b1, 8'($urandom), 8'($urandom)));
      send_tick(tick(1'b1, 1'b0, 8'($urandom), 8'($urandom)));
    end
    send_tick(tick(1'b0, 1'b1, 8'($urandom), 8'($urandom)));
    presses = int'(hum_set) + 1;
    repeat (presses) begin
      send_tick(tick(1'b1, 1'b1, 8'($urandom), 8'($urandom)));
      send_tick(tick(1'b1, 1'b0, 8'($urandom), 8'($urandom)));
    end
    send_tick(tick(1'b0, 1'b1, 8'($urandom), 8'($urandom)));
  endtask

  // Multi-tick limits with no idling: heat and pump run their full count, and the
  // fan stays humid well past its minimum before it is allowed to leave.
  task automatic test_long_timers();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    configure(10'd20, 10'd10, 10'd20);
    while (cur_phase != PH_HEAT) send_tick(random_tick());
    while (cur_phase == PH_HEAT) send_tick(tick(1'b1, 1'b1, 8'hFF, 8'h00));
    send_tick(tick(1'b1, 1'b1, 8'hFF, 8'h00));
    repeat (15) send_tick(tick(1'b1, 1'b1, 8'hFF, 8'h00));
    while (cur_phase == PH_FAN) send_tick(tick(1'b1, 1'b1, 8'h00, 8'h00));
    while (cur_phase == PH_PUMP) send_tick(tick(1'b1, 1'b1, 8'h00, 8'hFF));
  endtask

  // Output held off while input keeps coming: the core must fill and stall.
  task automatic test_output_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    hold_request = 1'b1;
    repeat (24) send_tick(random_tick());
  endtask

  // Random ticks under several register settings and idling mixes.
  task automatic test_random_mix();
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: configure(10'd1, 10'd1, 10'd1);
        1: configure(10'd2, 10'd0, 10'd9);
        default: configure(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 12)),
                           CFG_W'($urandom_range(0, 12)));
      endcase
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      repeat (10) send_tick(random_tick());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_presses_and_phases();
    test_zero_limits();
    test_setpoint_wrap();
    test_long_timers();
    test_output_backpressure();
    test_random_mix();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d ticks, %0d results compared, %0d complete drying cycles.",
             items_sent, results_checked, full_cycles);
    $display("Setpoint wraps: %0d temperature, %0d humidity; long output hold-offs: %0d.",
             temp_wraps, hum_wraps, holds_done);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: dryer_cycle_sequencer_core.f
hw/rtl/dcs_pkg.sv
hw/rtl/dryer_cycle_sequencer_core.sv
bench/tb_dryer_cycle_sequencer_core.sv
